/* hw/rtl/watch_clock_alarm_stopwatch_control_macros.svh */
// assertion macros for the watch controller
// used by watch_clock_alarm_stopwatch_control.sv; expects clk and rst_n in scope
`ifndef WATCH_CLOCK_ALARM_STOPWATCH_CONTROL_MACROS_SVH
`define WATCH_CLOCK_ALARM_STOPWATCH_CONTROL_MACROS_SVH

// condition implies consequence in the same cycle
`define WCAS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define WCAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/wcas_pkg.sv */
// shared types, codes and helpers for the watch controller
// no dependencies
`default_nettype none

package wcas_pkg;

    // top mode codes
    localparam logic [1:0] MODE_TIME      = 2'd0;
    localparam logic [1:0] MODE_SET_TIME  = 2'd1;
    localparam logic [1:0] MODE_SET_ALARM = 2'd2;
    localparam logic [1:0] MODE_WATCH     = 2'd3;

    // setter sub-state codes
    localparam logic [1:0] SUB_IDLE    = 2'd0;
    localparam logic [1:0] SUB_HOURS   = 2'd1;
    localparam logic [1:0] SUB_MINUTES = 2'd2;

    // stopwatch sub-state codes
    localparam logic [1:0] WSUB_IDLE    = 2'd0;
    localparam logic [1:0] WSUB_RUN     = 2'd1;
    localparam logic [1:0] WSUB_STOPPED = 2'd2;

    // counter limits
    localparam logic [4:0] HOURS_MAX   = 5'd23;
    localparam logic [5:0] MINUTES_MAX = 6'd59;
    localparam logic [5:0] SECONDS_MAX = 6'd59;
    localparam logic [3:0] TENTHS_MAX  = 4'd9;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [3:0] tenths;
    } hms_t;

    typedef struct packed {
        logic plus_b;
        logic minus_b;
        logic time_b;
        logic set_b;
        logic alarm_b;
        logic watch_b;
        logic toggle_b;
    } buttons_t;

    localparam hms_t HMS_ZERO = '0;

    // advance a time value by one tenth with carries
    function automatic hms_t tick_hms(hms_t t_in);
        hms_t r;
        r = t_in;
        if (t_in.tenths == TENTHS_MAX) begin
            r.tenths = '0;
            if (t_in.seconds == SECONDS_MAX) begin
                r.seconds = '0;
                if (t_in.minutes == MINUTES_MAX) begin
                    r.minutes = '0;
                    r.hours = (t_in.hours == HOURS_MAX) ? 5'd0 : t_in.hours + 5'd1;
                end else begin
                    r.minutes = t_in.minutes + 6'd1;
                end
            end else begin
                r.seconds = t_in.seconds + 6'd1;
            end
        end else begin
            r.tenths = t_in.tenths + 4'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/watch_clock_alarm_stopwatch_control.sv */
// watch controller top level: time of day, time and alarm setting, stopwatch
// depends on wcas_pkg and watch_clock_alarm_stopwatch_control_macros.svh
//
// Usage:
//   input channel (in_valid/in_ready) carries one tenth-second tick with the
//   seven button flags; output channel (out_valid/out_ready) carries one
//   display result per tick: digits, mode, blink flags, alarm armed, ringing.
//   A tick is captured in an input register, then the update logic updates
//   all watch state and loads the result register, which raises out_valid;
//   throughput is one tick per cycle while the receiver does not stall, set
//   by the single update stage.
//   While the receiver stalls the result stays in the output register and one
//   more tick can be captured in the input register; further ticks wait.
//   Reset clears all counters, puts the watch in time mode with alarm disarmed
//   and silent, and empties both registers.
`default_nettype none
`include "watch_clock_alarm_stopwatch_control_macros.svh"

module watch_clock_alarm_stopwatch_control
    import wcas_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       plus_button,
    input  wire logic       minus_button,
    input  wire logic       time_button,
    input  wire logic       set_button,
    input  wire logic       alarm_button,
    input  wire logic       watch_button,
    input  wire logic       alarm_toggle_button,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [4:0]      show_hours,
    output logic [5:0]      show_minutes,
    output logic [5:0]      show_seconds,
    output logic [3:0]      show_tenths,
    output logic [1:0]      mode_shown,
    output logic            hours_blink,
    output logic            minutes_blink,
    output logic            alarm_enabled,
    output logic            ringing
);

    // handshake registers
    logic       in_valid_reg;
    buttons_t   btn_reg;
    logic       out_valid_reg;
    logic       advance;

    // watch state
    hms_t       clock_reg, clock_next;
    logic [4:0] alarm_hours_reg, alarm_hours_next;
    logic [5:0] alarm_minutes_reg, alarm_minutes_next;
    hms_t       watch_reg, watch_next;
    logic       lap_hold_reg, lap_hold_next;
    logic [1:0] top_state_reg, top_state_next;
    logic [1:0] set_time_sub_reg, set_time_sub_next;
    logic [1:0] set_alarm_sub_reg, set_alarm_sub_next;
    logic [1:0] watch_sub_reg, watch_sub_next;
    logic       alarm_armed_reg, alarm_armed_next;
    logic       ring_reg, ring_next;
    hms_t       disp_reg, disp_next;
    logic [1:0] disp_mode_reg, disp_mode_next;
    logic       hblink_reg, hblink_next;
    logic       mblink_reg, mblink_next;

    // shared setter working values
    logic [1:0] set_sub;
    logic [4:0] set_h;
    logic [5:0] set_m;
    logic       set_swap;

    // pipeline control
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            btn_reg <= '{plus_b:   plus_button,
                         minus_b:  minus_button,
                         time_b:   time_button,
                         set_b:    set_button,
                         alarm_b:  alarm_button,
                         watch_b:  watch_button,
                         toggle_b: alarm_toggle_button};
        end
    end

    // tick update
    always_comb
    begin
        clock_next         = tick_hms(clock_reg);
        alarm_hours_next   = alarm_hours_reg;
        alarm_minutes_next = alarm_minutes_reg;
        watch_next         = watch_reg;
        lap_hold_next      = lap_hold_reg;
        top_state_next     = top_state_reg;
        set_time_sub_next  = set_time_sub_reg;
        set_alarm_sub_next = set_alarm_sub_reg;
        watch_sub_next     = watch_sub_reg;
        alarm_armed_next   = alarm_armed_reg;
        disp_next          = disp_reg;
        disp_mode_next     = disp_mode_reg;
        hblink_next        = hblink_reg;
        mblink_next        = mblink_reg;
        set_sub            = SUB_IDLE;
        set_h              = '0;
        set_m              = '0;
        set_swap           = 1'b0;

        // mode transitions
        unique case (top_state_reg)
            MODE_TIME:
            begin
                if (btn_reg.time_b)
                begin
                    top_state_next = MODE_TIME;
                end
                else if (btn_reg.set_b)
                begin
                    top_state_next = MODE_SET_TIME;
                    disp_mode_next = MODE_SET_TIME;
                end
                else if (btn_reg.watch_b)
                begin
                    top_state_next = MODE_WATCH;
                    disp_mode_next = MODE_WATCH;
                end
                else if (btn_reg.alarm_b)
                begin
                    top_state_next = MODE_SET_ALARM;
                    disp_mode_next = MODE_SET_ALARM;
                end
            end
            MODE_SET_TIME:
            begin
                if (btn_reg.time_b || btn_reg.alarm_b || btn_reg.watch_b)
                begin
                    set_time_sub_next = SUB_IDLE;
                    top_state_next = btn_reg.time_b ? MODE_TIME :
                                     (btn_reg.alarm_b ? MODE_SET_ALARM : MODE_WATCH);
                    disp_mode_next = top_state_next;
                    hblink_next = 1'b0;
                    mblink_next = 1'b0;
                end
            end
            MODE_SET_ALARM:
            begin
                if (btn_reg.time_b || btn_reg.set_b || btn_reg.watch_b || btn_reg.toggle_b)
                begin
                    set_alarm_sub_next = SUB_IDLE;
                    top_state_next = btn_reg.time_b ? MODE_TIME :
                                     (btn_reg.set_b ? MODE_SET_TIME :
                                     (btn_reg.watch_b ? MODE_WATCH : MODE_SET_ALARM));
                    disp_mode_next = top_state_next;
                    if (!btn_reg.time_b && !btn_reg.set_b && !btn_reg.watch_b)
                    begin
                        alarm_armed_next = !alarm_armed_reg;
                    end
                    hblink_next = 1'b0;
                    mblink_next = 1'b0;
                end
            end
            default:
            begin
                if (btn_reg.time_b || btn_reg.set_b || btn_reg.alarm_b)
                begin
                    watch_sub_next = WSUB_IDLE;
                    top_state_next = btn_reg.time_b ? MODE_TIME :
                                     (btn_reg.set_b ? MODE_SET_TIME : MODE_SET_ALARM);
                    disp_mode_next = top_state_next;
                end
            end
        endcase

        // active mode behavior
        unique case (top_state_next) inside
            MODE_TIME:
            begin
                disp_next = clock_next;
            end
            MODE_SET_TIME, MODE_SET_ALARM:
            begin
                // pick the time or alarm fields for the shared setter
                if (top_state_next == MODE_SET_TIME)
                begin
                    set_sub  = set_time_sub_next;
                    set_h    = clock_next.hours;
                    set_m    = clock_next.minutes;
                    set_swap = btn_reg.set_b;
                end
                else
                begin
                    set_sub  = set_alarm_sub_next;
                    set_h    = alarm_hours_next;
                    set_m    = alarm_minutes_next;
                    set_swap = btn_reg.alarm_b;
                end

                if (set_sub == SUB_IDLE ||
                    (set_sub == SUB_MINUTES && !btn_reg.plus_b && !btn_reg.minus_b
                     && set_swap))
                begin
                    set_sub = SUB_HOURS;
                    disp_next.minutes = set_m;
                    disp_next.hours = set_h;
                    hblink_next = 1'b1;
                    mblink_next = 1'b0;
                end
                else if (set_sub == SUB_HOURS)
                begin
                    if (btn_reg.plus_b)
                    begin
                        set_h = (set_h == HOURS_MAX) ? 5'd0 : set_h + 5'd1;
                        disp_next.minutes = set_m;
                        disp_next.hours = set_h;
                        hblink_next = 1'b1;
                    end
                    else if (btn_reg.minus_b)
                    begin
                        set_h = (set_h == 5'd0) ? HOURS_MAX : set_h - 5'd1;
                        disp_next.minutes = set_m;
                        disp_next.hours = set_h;
                        hblink_next = 1'b1;
                    end
                    else if (set_swap)
                    begin
                        set_sub = SUB_MINUTES;
                        hblink_next = 1'b0;
                        mblink_next = 1'b1;
                        disp_next.minutes = set_m;
                    end
                end
                else if (set_sub == SUB_MINUTES)
                begin
                    if (btn_reg.plus_b)
                    begin
                        set_m = (set_m == MINUTES_MAX) ? 6'd0 : set_m + 6'd1;
                        mblink_next = 1'b1;
                        disp_next.minutes = set_m;
                    end
                    else if (btn_reg.minus_b)
                    begin
                        set_m = (set_m == 6'd0) ? MINUTES_MAX : set_m - 6'd1;
                        mblink_next = 1'b1;
                        disp_next.minutes = set_m;
                    end
                end

                // write the setter results back
                if (top_state_next == MODE_SET_TIME)
                begin
                    set_time_sub_next  = set_sub;
                    clock_next.hours   = set_h;
                    clock_next.minutes = set_m;
                end
                else
                begin
                    set_alarm_sub_next = set_sub;
                    alarm_hours_next   = set_h;
                    alarm_minutes_next = set_m;
                end
            end
            default:
            begin
                // stopwatch
                if (watch_sub_next == WSUB_IDLE)
                begin
                    watch_sub_next = WSUB_STOPPED;
                    watch_next = HMS_ZERO;
                    disp_next = HMS_ZERO;
                end
                else if (watch_sub_next == WSUB_STOPPED)
                begin
                    if (btn_reg.watch_b)
                    begin
                        watch_next = HMS_ZERO;
                        disp_next = HMS_ZERO;
                    end
                    else if (!btn_reg.minus_b && btn_reg.plus_b)
                    begin
                        lap_hold_next = 1'b0;
                        watch_sub_next = WSUB_RUN;
                    end
                end
                else if (watch_sub_next == WSUB_RUN)
                begin
                    watch_next = tick_hms(watch_reg);
                    if (btn_reg.watch_b)
                    begin
                        watch_sub_next = WSUB_STOPPED;
                        watch_next = HMS_ZERO;
                        disp_next = HMS_ZERO;
                    end
                    else if (btn_reg.minus_b)
                    begin
                        lap_hold_next = !lap_hold_reg;
                    end
                    else if (btn_reg.plus_b)
                    begin
                        if (lap_hold_reg)
                        begin
                            lap_hold_next = 1'b0;
                        end
                        else
                        begin
                            lap_hold_next = 1'b1;
                            watch_sub_next = WSUB_STOPPED;
                            disp_next = watch_next;
                        end
                    end
                    if (!lap_hold_next)
                    begin
                        disp_next = watch_next;
                    end
                end
            end
        endcase

        // ring when armed and the clock matches the alarm
        ring_next = alarm_armed_next && (clock_next.hours == alarm_hours_next)
                    && (clock_next.minutes == alarm_minutes_next);
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg         <= HMS_ZERO;
            alarm_hours_reg   <= '0;
            alarm_minutes_reg <= '0;
            watch_reg         <= HMS_ZERO;
            lap_hold_reg      <= 1'b0;
            top_state_reg     <= MODE_TIME;
            set_time_sub_reg  <= SUB_IDLE;
            set_alarm_sub_reg <= SUB_IDLE;
            watch_sub_reg     <= WSUB_IDLE;
            alarm_armed_reg   <= 1'b0;
            ring_reg          <= 1'b0;
            disp_reg          <= HMS_ZERO;
            disp_mode_reg     <= MODE_TIME;
            hblink_reg        <= 1'b0;
            mblink_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                clock_reg         <= clock_next;
                alarm_hours_reg   <= alarm_hours_next;
                alarm_minutes_reg <= alarm_minutes_next;
                watch_reg         <= watch_next;
                lap_hold_reg      <= lap_hold_next;
                top_state_reg     <= top_state_next;
                set_time_sub_reg  <= set_time_sub_next;
                set_alarm_sub_reg <= set_alarm_sub_next;
                watch_sub_reg     <= watch_sub_next;
                alarm_armed_reg   <= alarm_armed_next;
                ring_reg          <= ring_next;
                disp_reg          <= disp_next;
                disp_mode_reg     <= disp_mode_next;
                hblink_reg        <= hblink_next;
                mblink_reg        <= mblink_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result ports
    assign out_valid     = out_valid_reg;
    assign show_hours    = disp_reg.hours;
    assign show_minutes  = disp_reg.minutes;
    assign show_seconds  = disp_reg.seconds;
    assign show_tenths   = disp_reg.tenths;
    assign mode_shown    = disp_mode_reg;
    assign hours_blink   = hblink_reg;
    assign minutes_blink = mblink_reg;
    assign alarm_enabled = alarm_armed_reg;
    assign ringing       = ring_reg;

    // checks
    `WCAS_ASSERT_SAME(a_ring_needs_armed, ring_reg, alarm_armed_reg, "ringing while disarmed")
    `WCAS_ASSERT_SAME(a_blink_exclusive, hblink_reg, !mblink_reg, "both blink flags set")
    `WCAS_ASSERT_SAME(a_mode_shown_tracks, 1'b1, disp_mode_reg == top_state_reg, "mode shown differs from mode")
    `WCAS_ASSERT_NEXT(a_advance_gives_result, advance, out_valid_reg, "update without result")

endmodule

`default_nettype wire

/* tb/sv/tb_watch_clock_alarm_stopwatch_control.sv */
// self-checking testbench for watch_clock_alarm_stopwatch_control
// depends on wcas_pkg and the dut; a tick-level predictor or a typed row checks every result
// directed button table first, then random button sessions with random handshake gaps

module tb_watch_clock_alarm_stopwatch_control;
    import wcas_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICK_TARGET = 1100;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_CAP   = 100;

    // one displayed result, field for field as on the output ports
    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [3:0] tenths;
        logic [1:0] mode;
        logic       hblink;
        logic       mblink;
        logic       armed;
        logic       ring;
    } face_t;

    // directed row: buttons, and a hand-written result where one is given
    typedef struct packed {
        buttons_t b;
        logic     typed;
        face_t    want;
    } plan_row_t;

    // button patterns, single, none and all (plus, minus, time, set, alarm, watch, toggle)
    localparam buttons_t B_NONE   = 7'b0000000;
    localparam buttons_t B_PLUS   = 7'b1000000;
    localparam buttons_t B_MINUS  = 7'b0100000;
    localparam buttons_t B_TIME   = 7'b0010000;
    localparam buttons_t B_SET    = 7'b0001000;
    localparam buttons_t B_ALARM  = 7'b0000100;
    localparam buttons_t B_WATCH  = 7'b0000010;
    localparam buttons_t B_TOGGLE = 7'b0000001;
    localparam buttons_t B_ALL    = 7'b1111111;

    // directed walk: reset state, hour and minute wrap both ways, field swap,
    // alarm arm and disarm while ringing, stopwatch run, lap and reset,
    // button priorities between modes
    localparam plan_row_t PLAN [0:24] = '{
        '{B_NONE,   1'b1, '{5'd0,  6'd0, 6'd0, 4'd1, MODE_TIME,      1'b0, 1'b0, 1'b0, 1'b0}},
        '{B_SET,    1'b1, '{5'd0,  6'd0, 6'd0, 4'd1, MODE_SET_TIME,  1'b1, 1'b0, 1'b0, 1'b0}},
        '{B_MINUS,  1'b1, '{5'd23, 6'd0, 6'd0, 4'd1, MODE_SET_TIME,  1'b1, 1'b0, 1'b0, 1'b0}},
        '{B_PLUS,   1'b1, '{5'd0,  6'd0, 6'd0, 4'd1, MODE_SET_TIME,  1'b1, 1'b0, 1'b0, 1'b0}},
        '{B_SET,    1'b0, '0},
        '{B_MINUS,  1'b0, '0},
        '{B_PLUS,   1'b0, '0},
        '{B_SET,    1'b0, '0},
        '{B_ALARM,  1'b0, '0},
        '{B_ALARM,  1'b0, '0},
        '{B_TOGGLE, 1'b1, '{5'd0,  6'd0, 6'd0, 4'd1, MODE_SET_ALARM, 1'b1, 1'b0, 1'b1, 1'b1}},
        '{B_TOGGLE, 1'b1, '{5'd0,  6'd0, 6'd0, 4'd1, MODE_SET_ALARM, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{B_TOGGLE, 1'b0, '0},
        '{B_WATCH,  1'b0, '0},
        '{B_PLUS,   1'b0, '0},
        '{B_NONE,   1'b0, '0},
        '{B_MINUS,  1'b0, '0},
        '{B_PLUS,   1'b0, '0},
        '{B_PLUS,   1'b0, '0},
        '{B_WATCH,  1'b0, '0},
        '{B_PLUS | B_MINUS, 1'b0, '0},
        '{B_ALL,    1'b0, '0},
        '{B_WATCH | B_ALARM, 1'b0, '0},
        '{B_SET | B_ALARM,   1'b0, '0},
        '{B_TIME,   1'b0, '0}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       plus_button = 1'b0;
    logic       minus_button = 1'b0;
    logic       time_button = 1'b0;
    logic       set_button = 1'b0;
    logic       alarm_button = 1'b0;
    logic       watch_button = 1'b0;
    logic       alarm_toggle_button = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [4:0] show_hours;
    logic [5:0] show_minutes;
    logic [5:0] show_seconds;
    logic [3:0] show_tenths;
    logic [1:0] mode_shown;
    logic       hours_blink;
    logic       minutes_blink;
    logic       alarm_enabled;
    logic       ringing;

    watch_clock_alarm_stopwatch_control dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .plus_button         (plus_button),
        .minus_button        (minus_button),
        .time_button         (time_button),
        .set_button          (set_button),
        .alarm_button        (alarm_button),
        .watch_button        (watch_button),
        .alarm_toggle_button (alarm_toggle_button),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .show_hours          (show_hours),
        .show_minutes        (show_minutes),
        .show_seconds        (show_seconds),
        .show_tenths         (show_tenths),
        .mode_shown          (mode_shown),
        .hours_blink         (hours_blink),
        .minutes_blink       (minutes_blink),
        .alarm_enabled       (alarm_enabled),
        .ringing             (ringing)
    );

    // predicted watch state
    logic [4:0] tod_h = '0, alm_h = '0, sw_h = '0;
    logic [5:0] tod_m = '0, tod_s = '0, alm_m = '0, sw_m = '0, sw_s = '0;
    logic [3:0] tod_t = '0, sw_t = '0;
    logic       lap_frozen = 1'b0;
    logic       armed = 1'b0;
    logic [1:0] mode_now = MODE_TIME;
    logic [1:0] tset_field = SUB_IDLE;
    logic [1:0] aset_field = SUB_IDLE;
    logic [1:0] sw_phase = WSUB_IDLE;
    face_t      face = '0;

    // expected results not yet seen, oldest first
    face_t due_faces [$];

    int bad_count = 0;
    int ticks_sent = 0;
    int faces_seen = 0;
    int rings_seen = 0;
    int midnights = 0;
    int snd_style = 1;
    int rcv_style = 1;

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results still outstanding",
                 cycles, due_faces.size());
        $display("Some tests failed");
        $finish;
    end

    task automatic report_error(input string msg);
        if (bad_count < PRINT_CAP)
            $display("ERROR at %0t: %s", $realtime, msg);
        bad_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("result %0d %s: got %0d, expected %0d",
                                   faces_seen, name, got, want));
    endtask

    // gap length: none, uniform, or mostly back to back
    function automatic int draw_gap(input int style);
        case (style)
            0:       return 0;
            1:       return $urandom_range(12);
            default: return ($urandom_range(7) == 0) ? $urandom_range(12) : 0;
        endcase
    endfunction

    function automatic buttons_t rand_buttons(input int odds);
        buttons_t r;
        r.plus_b   = ($urandom_range(odds - 1) == 0);
        r.minus_b  = ($urandom_range(odds - 1) == 0);
        r.time_b   = ($urandom_range(odds - 1) == 0);
        r.set_b    = ($urandom_range(odds - 1) == 0);
        r.alarm_b  = ($urandom_range(odds - 1) == 0);
        r.watch_b  = ($urandom_range(odds - 1) == 0);
        r.toggle_b = ($urandom_range(odds - 1) == 0);
        return r;
    endfunction

    // one tenth with carries into seconds, minutes and hours
    task automatic add_tenth(inout logic [4:0] h, inout logic [5:0] m,
                             inout logic [5:0] s, inout logic [3:0] t);
        if (t == TENTHS_MAX)
        begin
            t = 4'd0;
            if (s == SECONDS_MAX)
            begin
                s = 6'd0;
                if (m == MINUTES_MAX)
                begin
                    m = 6'd0;
                    h = (h == HOURS_MAX) ? 5'd0 : h + 5'd1;
                end
                else
                    m = m + 6'd1;
            end
            else
                s = s + 6'd1;
        end
        else
            t = t + 4'd1;
    endtask

    task automatic show_hms(input logic [4:0] h, input logic [5:0] m,
                            input logic [5:0] s, input logic [3:0] t);
        face.hours   = h;
        face.minutes = m;
        face.seconds = s;
        face.tenths  = t;
    endtask

    task automatic show_stopwatch();
        show_hms(sw_h, sw_m, sw_s, sw_t);
    endtask

    task automatic clear_stopwatch();
        sw_h = '0;
        sw_m = '0;
        sw_s = '0;
        sw_t = '0;
    endtask

    task automatic enter_mode(input logic [1:0] m);
        mode_now  = m;
        face.mode = m;
    endtask

    // hour/minute field editor shared by time and alarm setting
    task automatic step_setter(inout logic [1:0] field, inout logic [4:0] h,
                               inout logic [5:0] m, input logic plus,
                               input logic minus, input logic swap);
        if (field == SUB_IDLE || (field == SUB_MINUTES && !plus && !minus && swap))
        begin
            field        = SUB_HOURS;
            face.minutes = m;
            face.hblink  = 1'b1;
            face.mblink  = 1'b0;
            face.hours   = h;
        end
        else if (field == SUB_HOURS)
        begin
            if (plus || minus)
            begin
                if (plus)
                    h = (h == HOURS_MAX) ? 5'd0 : h + 5'd1;
                else
                    h = (h == 5'd0) ? HOURS_MAX : h - 5'd1;
                face.minutes = m;
                face.hblink  = 1'b1;
                face.hours   = h;
            end
            else if (swap)
            begin
                field        = SUB_MINUTES;
                face.hblink  = 1'b0;
                face.mblink  = 1'b1;
                face.minutes = m;
            end
        end
        else if (field == SUB_MINUTES)
        begin
            if (plus || minus)
            begin
                if (plus)
                    m = (m == MINUTES_MAX) ? 6'd0 : m + 6'd1;
                else
                    m = (m == 6'd0) ? MINUTES_MAX : m - 6'd1;
                face.mblink  = 1'b1;
                face.minutes = m;
            end
        end
    endtask

    // stopwatch: stopped, running, lap freeze of the display
    task automatic step_stopwatch(input logic plus, input logic minus, input logic wb);
        if (sw_phase == WSUB_IDLE)
        begin
            sw_phase = WSUB_STOPPED;
            clear_stopwatch();
            show_stopwatch();
        end
        else if (sw_phase == WSUB_STOPPED)
        begin
            if (wb)
            begin
                clear_stopwatch();
                show_stopwatch();
            end
            else if (!minus && plus)
            begin
                lap_frozen = 1'b0;
                sw_phase   = WSUB_RUN;
            end
        end
        else if (sw_phase == WSUB_RUN)
        begin
            add_tenth(sw_h, sw_m, sw_s, sw_t);
            if (wb)
            begin
                sw_phase = WSUB_STOPPED;
                clear_stopwatch();
                show_stopwatch();
            end
            else if (minus)
                lap_frozen = !lap_frozen;
            else if (plus)
            begin
                if (lap_frozen)
                    lap_frozen = 1'b0;
                else
                begin
                    lap_frozen = 1'b1;
                    sw_phase   = WSUB_STOPPED;
                    show_stopwatch();
                end
            end
            if (!lap_frozen)
                show_stopwatch();
        end
    endtask

    // predict the display after one tick
    task automatic advance_watch(input buttons_t b, output face_t f);
        add_tenth(tod_h, tod_m, tod_s, tod_t);
        if ({tod_h, tod_m, tod_s, tod_t} == '0)
            midnights++;

        // mode change on buttons
        case (mode_now)
            MODE_TIME:
            begin
                if (!b.time_b)
                begin
                    if (b.set_b)
                        enter_mode(MODE_SET_TIME);
                    else if (b.watch_b)
                        enter_mode(MODE_WATCH);
                    else if (b.alarm_b)
                        enter_mode(MODE_SET_ALARM);
                end
            end
            MODE_SET_TIME:
            begin
                if (b.time_b || b.alarm_b || b.watch_b)
                begin
                    tset_field = SUB_IDLE;
                    enter_mode(b.time_b ? MODE_TIME :
                               (b.alarm_b ? MODE_SET_ALARM : MODE_WATCH));
                    face.hblink = 1'b0;
                    face.mblink = 1'b0;
                end
            end
            MODE_SET_ALARM:
            begin
                if (b.time_b || b.set_b || b.watch_b || b.toggle_b)
                begin
                    aset_field = SUB_IDLE;
                    enter_mode(b.time_b ? MODE_TIME : (b.set_b ? MODE_SET_TIME :
                               (b.watch_b ? MODE_WATCH : MODE_SET_ALARM)));
                    // toggle alone re-enters alarm setting and flips the arming
                    if (!b.time_b && !b.set_b && !b.watch_b)
                        armed = !armed;
                    face.hblink = 1'b0;
                    face.mblink = 1'b0;
                end
            end
            default:
            begin
                if (b.time_b || b.set_b || b.alarm_b)
                begin
                    sw_phase = WSUB_IDLE;
                    enter_mode(b.time_b ? MODE_TIME :
                               (b.set_b ? MODE_SET_TIME : MODE_SET_ALARM));
                end
            end
        endcase

        // active mode runs, possibly the one just entered
        case (mode_now)
            MODE_TIME:      show_hms(tod_h, tod_m, tod_s, tod_t);
            MODE_SET_TIME:  step_setter(tset_field, tod_h, tod_m, b.plus_b, b.minus_b, b.set_b);
            MODE_SET_ALARM: step_setter(aset_field, alm_h, alm_m, b.plus_b, b.minus_b, b.alarm_b);
            default:        step_stopwatch(b.plus_b, b.minus_b, b.watch_b);
        endcase

        face.armed = armed;
        face.ring  = armed && tod_h == alm_h && tod_m == alm_m;
        f = face;
    endtask

    // one tick transfer on the input channel, then its prediction
    task automatic send_tick(input buttons_t b, input logic typed, input face_t want);
        int    gap;
        face_t predicted;
        gap = draw_gap(snd_style);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid            <= 1'b1;
        plus_button         <= b.plus_b;
        minus_button        <= b.minus_b;
        time_button         <= b.time_b;
        set_button          <= b.set_b;
        alarm_button        <= b.alarm_b;
        watch_button        <= b.watch_b;
        alarm_toggle_button <= b.toggle_b;
        do
            @(posedge clk);
        while (!in_ready);
        advance_watch(b, predicted);
        due_faces.push_back(typed ? want : predicted);
        ticks_sent++;
    endtask

    task automatic tap(input buttons_t b);
        send_tick(b, 1'b0, '0);
    endtask

    // hold off the sender until every expected result has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_faces.size() != 0);
    endtask

    // well-formed setting: time, enter setter, dial hours, swap, dial minutes, arming, time
    task automatic dial_in(input bit for_alarm, input int th, input int tm, input bit arm);
        buttons_t own;
        int       cur;
        int       n;
        own = for_alarm ? B_ALARM : B_SET;
        tap(B_TIME);
        tap(own);
        for (n = 0; n < 24; n++)
        begin
            cur = for_alarm ? int'(alm_h) : int'(tod_h);
            if (cur == th)
                break;
            tap((((th - cur + 24) % 24) <= 12) ? B_PLUS : B_MINUS);
        end
        tap(own);
        for (n = 0; n < 60; n++)
        begin
            cur = for_alarm ? int'(alm_m) : int'(tod_m);
            if (cur == tm)
                break;
            tap((((tm - cur + 60) % 60) <= 30) ? B_PLUS : B_MINUS);
        end
        if (for_alarm && armed != arm)
            tap(B_TOGGLE);
        tap(B_TIME);
    endtask

    // result side: random stalls, then compare each transfer with the oldest expected result
    initial
    begin : result_sink
        int    stall;
        face_t got;
        face_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap(rcv_style);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            got = '{show_hours, show_minutes, show_seconds, show_tenths, mode_shown,
                    hours_blink, minutes_blink, alarm_enabled, ringing};
            faces_seen++;
            if (faces_seen % 40 == 0)
                rcv_style = $urandom_range(2);
            if (due_faces.size() == 0)
                report_error($sformatf("result %0d arrived with nothing outstanding",
                                       faces_seen));
            else
            begin
                want = due_faces.pop_front();
                check_field("hours",         int'(got.hours),   int'(want.hours));
                check_field("minutes",       int'(got.minutes), int'(want.minutes));
                check_field("seconds",       int'(got.seconds), int'(want.seconds));
                check_field("tenths",        int'(got.tenths),  int'(want.tenths));
                check_field("mode",          int'(got.mode),    int'(want.mode));
                check_field("hours_blink",   int'(got.hblink),  int'(want.hblink));
                check_field("minutes_blink", int'(got.mblink),  int'(want.mblink));
                check_field("alarm_enabled", int'(got.armed),   int'(want.armed));
                check_field("ringing",       int'(got.ring),    int'(want.ring));
                if (want.ring)
                    rings_seen++;
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        buttons_t b;
        bit       into_alarm;
        bit       midnight_done;
        int       n;
        int       start;
        midnight_done = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (PLAN[i])
            send_tick(PLAN[i].b, PLAN[i].typed, PLAN[i].want);
        drain_results();

        // random sessions
        while (ticks_sent < TICK_TARGET)
        begin
            snd_style = $urandom_range(2);
            if (!midnight_done && tod_s >= 6'd45)
            begin
                // clock set just short of midnight, then left to roll over
                dial_in(1'b0, 23, 59, 1'b0);
                start = midnights;
                for (n = 0; n < 200 && midnights == start; n++)
                    tap(B_NONE);
                repeat (5) tap(B_NONE);
                midnight_done = 1'b1;
            end
            else
            begin
                case ($urandom_range(9))
                    0:
                    begin
                        // noise: every button at even odds
                        repeat ($urandom_range(5, 30)) tap(rand_buttons(2));
                    end
                    1, 2:
                    begin
                        // sparse presses, modes persist
                        repeat ($urandom_range(10, 60)) tap(rand_buttons(16));
                    end
                    3:
                    begin
                        dial_in(1'b0, $urandom_range(23), $urandom_range(59), 1'b0);
                        repeat ($urandom_range(5, 40)) tap(rand_buttons(40));
                    end
                    4:
                    begin
                        // alarm on the current or next minute, armed, then wait
                        dial_in(1'b1, int'(tod_h), (tod_m + $urandom_range(1)) % 60, 1'b1);
                        repeat ($urandom_range(30, 150)) tap(rand_buttons(60));
                    end
                    5, 6:
                    begin
                        // setter session with random plus, minus and field swaps
                        into_alarm = 1'($urandom_range(1));
                        tap(B_TIME);
                        tap(into_alarm ? B_ALARM : B_SET);
                        repeat ($urandom_range(10, 50))
                        begin
                            b = rand_buttons(30);
                            n = $urandom_range(3);
                            b.plus_b  = b.plus_b | (n == 0);
                            b.minus_b = b.minus_b | (n == 1);
                            if (into_alarm)
                                b.alarm_b = b.alarm_b | (n == 2);
                            else
                                b.set_b = b.set_b | (n == 2);
                            tap(b);
                        end
                    end
                    7, 8:
                    begin
                        // stopwatch session: run, lap, stop, reset
                        tap(B_TIME);
                        tap(B_WATCH);
                        repeat ($urandom_range(20, 80))
                        begin
                            b = rand_buttons(50);
                            b.plus_b  = b.plus_b | ($urandom_range(5) == 0);
                            b.minus_b = b.minus_b | ($urandom_range(7) == 0);
                            b.watch_b = b.watch_b | ($urandom_range(11) == 0);
                            tap(b);
                        end
                    end
                    default:
                    begin
                        // broken sequence: enter a mode, then noise
                        tap($urandom_range(1) ? B_ALARM : B_SET);
                        repeat ($urandom_range(3, 12)) tap(rand_buttons(3));
                    end
                endcase
            end
            if ($urandom_range(9) == 0)
                drain_results();
        end

        drain_results();
        repeat (8) @(posedge clk);

        $display("covered %0d ticks, %0d results checked, %0d of them ringing",
                 ticks_sent, faces_seen, rings_seen);
        $display("clock crossed midnight %0d time(s), %0d field mismatches",
                 midnights, bad_count);
        if (bad_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
